/* rtl/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int MAX_SIDES = 64;
   localparam int ADDR_W    = $clog2(MAX_SIDES);
   localparam int COUNT_W   = $clog2(MAX_SIDES + 1);
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int CFG_W     = 7;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } vstore_wr_type;

endpackage

/* rtl/pip_vertex_store.sv */
// ----------------------------------------------------------------------------
// pip_vertex_store
// Vertex x/y memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pip_vertex_store
   import pip_pkg::*;
(
   input  logic               clock,
   input  vstore_wr_type      wr,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [COORD_W-1:0] rd_x,
   output logic [COORD_W-1:0] rd_y
);

   logic [COORD_W-1:0] mem_x [MAX_SIDES];
   logic [COORD_W-1:0] mem_y [MAX_SIDES];
   logic [COORD_W-1:0] rd_x_ff;
   logic [COORD_W-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_x[wr.addr] <= wr.x;
         mem_y[wr.addr] <= wr.y;
      end
   end

   always_ff @(posedge clock) begin
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

/* rtl/point_in_polygon_test.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a query point against a stored polygon.
//
//   channel  ports                           direction  handshake
//   request  start, busy, req_*              in         start & !busy
//   response rsp_valid, rsp_inside_res       out        one-cycle strobe
//   csr      csr_write_en, csr_side_count    in         write on enable
//
// A load transaction returns nothing.
// A query holds busy over FETCH, PRIME, EDGE_ST/MUL_L/MUL_R for each of n
// vertices, and FINISH (FINISH alone for n = 0); its response strobes in the
// next cycle: one shared 33x33 multiplier forms each edge's two cross products in turn.
// Reset is synchronous; side_count returns to 3, vertex memory is not cleared.
// Results cannot be stalled; rsp_valid is high for one cycle per query.
// ----------------------------------------------------------------------------
module point_in_polygon_test
   import pip_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic [ADDR_W-1:0]         req_vertex_index,
   input  logic signed [COORD_W-1:0] req_load_x,
   input  logic signed [COORD_W-1:0] req_load_y,
   input  logic signed [COORD_W-1:0] req_query_x,
   input  logic signed [COORD_W-1:0] req_query_y,
   output logic                      rsp_valid,
   output logic                      rsp_inside_res,
   input  logic                      csr_write_en,
   input  logic [CFG_W-1:0]          csr_side_count
);

   typedef enum logic [2:0] {
      IDLE, FETCH, PRIME, EDGE_ST, MUL_L, MUL_R, FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [CFG_W-1:0]          side_count_ff, side_count_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [COUNT_W-1:0]        edge_cnt_ff, edge_cnt_in;
   logic                      pend_ff, pend_in;
   logic                      inside_ff, inside_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_inside_ff, rsp_inside_in;
   logic signed [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [COORD_W-1:0] xj_ff, xj_in, yj_ff, yj_in;
   logic signed [DIFF_W-1:0]  dyi_ff, dyi_in, dxji_ff, dxji_in;
   logic signed [DIFF_W-1:0]  dxi_ff, dxi_in, dy_ff, dy_in;
   logic                      straddle_ff, straddle_in;
   logic                      dy_pos_ff, dy_pos_in;
   logic signed [PROD_W-1:0]  prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;

   logic signed [DIFF_W-1:0]  mult_a, mult_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [COORD_W-1:0] xi, yi;
   logic [COORD_W-1:0]        rd_x, rd_y;
   logic [COUNT_W-1:0]        n_sat;
   logic                      accept;
   logic                      left_hit;
   logic                      resolved;
   vstore_wr_type             store_wr;

   pip_vertex_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (addr_ff),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   assign accept        = start && !busy;
   assign store_wr.en   = accept && (req_action == ACTION_LOAD);
   assign store_wr.addr = req_vertex_index;
   assign store_wr.x    = req_load_x;
   assign store_wr.y    = req_load_y;

   assign xi = signed'(rd_x);
   assign yi = signed'(rd_y);

   // shared multiplier
   always_comb begin
      if (state_ff == MUL_R) begin
         mult_a = dxi_ff;
         mult_b = dy_ff;
      end else begin
         mult_a = dyi_ff;
         mult_b = dxji_ff;
      end
   end
   assign product = mult_a * mult_b;

   assign left_hit = dy_pos_ff ? (prod_l_ff < prod_r_ff) : (prod_r_ff < prod_l_ff);
   assign resolved = inside_ff ^ (pend_ff && straddle_ff && left_hit);

   always_comb begin
      if (32'(side_count_ff) > 32'(MAX_SIDES)) begin
         n_sat = COUNT_W'(MAX_SIDES);
      end else begin
         n_sat = COUNT_W'(side_count_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      side_count_in = csr_write_en ? csr_side_count : side_count_ff;
      addr_in       = addr_ff;
      edge_cnt_in   = edge_cnt_ff;
      pend_in       = pend_ff;
      inside_in     = inside_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = rsp_inside_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      xj_in         = xj_ff;
      yj_in         = yj_ff;
      dyi_in        = dyi_ff;
      dxji_in       = dxji_ff;
      dxi_in        = dxi_ff;
      dy_in         = dy_ff;
      straddle_in   = straddle_ff;
      dy_pos_in     = dy_pos_ff;
      prod_l_in     = prod_l_ff;
      prod_r_in     = prod_r_ff;

      case (state_ff)
         IDLE: begin
            if (accept && (req_action == ACTION_QUERY)) begin
               qx_in       = req_query_x;
               qy_in       = req_query_y;
               inside_in   = 1'b0;
               pend_in     = 1'b0;
               edge_cnt_in = n_sat;
               if (n_sat == '0) begin
                  state_in = FINISH;
               end else begin
                  addr_in  = ADDR_W'(n_sat - 1'b1);
                  state_in = FETCH;
               end
            end
         end
         FETCH: begin
            addr_in  = '0;
            state_in = PRIME;
         end
         PRIME: begin
            xj_in    = signed'(rd_x);
            yj_in    = signed'(rd_y);
            state_in = EDGE_ST;
         end
         EDGE_ST: begin
            inside_in   = resolved;
            pend_in     = 1'b0;
            straddle_in = ((yi < qy_ff) && (yj_ff >= qy_ff)) ||
                          ((yj_ff < qy_ff) && (yi >= qy_ff));
            dyi_in      = DIFF_W'(qy_ff) - DIFF_W'(yi);
            dxji_in     = DIFF_W'(xj_ff) - DIFF_W'(xi);
            dxi_in      = DIFF_W'(qx_ff) - DIFF_W'(xi);
            dy_in       = DIFF_W'(yj_ff) - DIFF_W'(yi);
            dy_pos_in   = yj_ff > yi;
            xj_in       = xi;
            yj_in       = yi;
            addr_in     = addr_ff + 1'b1;
            state_in    = MUL_L;
         end
         MUL_L: begin
            prod_l_in = product;
            state_in  = MUL_R;
         end
         MUL_R: begin
            prod_r_in   = product;
            pend_in     = 1'b1;
            edge_cnt_in = edge_cnt_ff - 1'b1;
            state_in    = (edge_cnt_ff == COUNT_W'(1)) ? FINISH : EDGE_ST;
         end
         FINISH: begin
            inside_in     = resolved;
            pend_in       = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_inside_in = resolved;
            state_in      = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         side_count_ff <= CFG_W'(3);
         edge_cnt_ff   <= '0;
         pend_ff       <= 1'b0;
         inside_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         side_count_ff <= side_count_in;
         edge_cnt_ff   <= edge_cnt_in;
         pend_ff       <= pend_in;
         inside_ff     <= inside_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      rsp_inside_ff <= rsp_inside_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      xj_ff         <= xj_in;
      yj_ff         <= yj_in;
      dyi_ff        <= dyi_in;
      dxji_ff       <= dxji_in;
      dxi_ff        <= dxi_in;
      dy_ff         <= dy_in;
      straddle_ff   <= straddle_in;
      dy_pos_ff     <= dy_pos_in;
      prod_l_ff     <= prod_l_in;
      prod_r_ff     <= prod_r_in;
   end

   assign busy           = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // a response only follows the finish step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == FINISH))
      else $error("response without a finished query");

   // an accepted query occupies the block
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACTION_QUERY) |=> busy)
      else $error("query transaction did not start the walk");

   // a load returns nothing and frees the block at once
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACTION_LOAD) |=> (!busy && !rsp_valid))
      else $error("load transaction produced activity");

endmodule
